// File: sv/qcspc_pkg.sv
package qcspc_pkg;

	localparam int MAX_MODULUS_DEF = 64;
	localparam int RES_W = 7;
	localparam int RAW_W = 8;
	localparam int CNT_W = 8;
	localparam int COEF_W = 6;
	localparam int SH_W = 3;
	localparam int WIDE_W = RAW_W + 6;
	localparam logic [SH_W-1:0] RED_FIRST = 3'd6;
	localparam logic [RES_W-1:0] MOD_MIN = 7'd3;
	localparam logic [RES_W-1:0] MOD_RESET = 7'd3;

	typedef struct packed {
		logic load;
		logic reduce;
		logic [SH_W-1:0] k;
		logic step;
	} cell_ctl_t;

endpackage

// File: sv/qcspc_coef_if.sv
interface qcspc_coef_if;
	logic valid;
	logic ready;
	logic [qcspc_pkg::COEF_W-1:0] coef_quadratic;
	logic [qcspc_pkg::COEF_W-1:0] coef_linear;
	logic [qcspc_pkg::COEF_W-1:0] coef_constant;

	modport source (output valid, coef_quadratic, coef_linear, coef_constant, input ready);
	modport sink (input valid, coef_quadratic, coef_linear, coef_constant, output ready);
endinterface

// File: sv/qcspc_result_if.sv
interface qcspc_result_if;
	logic valid;
	logic ready;
	logic [qcspc_pkg::CNT_W-1:0] smooth_points;
	logic [qcspc_pkg::CNT_W-1:0] twist_points;
	logic pointless;
	logic twist_pointless;

	modport source (output valid, smooth_points, twist_points, pointless, twist_pointless,
		input ready);
	modport sink (input valid, smooth_points, twist_points, pointless, twist_pointless,
		output ready);
endinterface

// File: sv/qcspc_cfg_if.sv
interface qcspc_cfg_if;
	logic valid;
	logic ready;
	logic [qcspc_pkg::RES_W-1:0] modulus;

	modport source (output valid, modulus, input ready);
	modport sink (input valid, modulus, output ready);
endinterface

// File: sv/quartic_curve_smooth_point_count_core.sv
// Counts affine smooth points of y^2 = x^4 + f2*x^2 + f1*x + f0 and of its
// quadratic twist over the integers modulo a configured p. One coefficient beat
// yields one result beat. For each item the ST_RED state first reduces the
// starting differences modulo p, then a row of difference cells steps f(x), f'(x)
// and x^2 one value of x per cycle, and ST_WAIT drains the square-table read
// and the final sum, holding while the result port is busy. After reset and
// after each accepted modulus write the square table is rebuilt, during which no
// coefficient beat is taken. A modulus write outside 3..MAX_MODULUS is ignored.
// A new item may be taken while the previous result still waits on its port.
module quartic_curve_smooth_point_count_core #(
	parameter int MAX_MODULUS = qcspc_pkg::MAX_MODULUS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	qcspc_cfg_if.sink            cfg,
	qcspc_coef_if.sink           coef,
	qcspc_result_if.source       result
);

	localparam int AW = (MAX_MODULUS > 1) ? $clog2(MAX_MODULUS) : 1;
	localparam int RW = qcspc_pkg::RES_W;
	localparam int XW = qcspc_pkg::RAW_W;
	localparam int CW = qcspc_pkg::CNT_W;

	typedef enum logic [2:0] {
		ST_CLR, ST_FRED, ST_FILL, ST_IDLE, ST_RED, ST_RUN, ST_WAIT
	} state_t;

	state_t state_q;
	logic [RW-1:0] mod_q;
	logic [RW-1:0] x_q;
	logic [qcspc_pkg::SH_W-1:0] k_q;
	logic [AW-1:0] clr_q;
	logic vld_s1;
	logic last_s1;
	logic vz_s1;
	logic dz_s1;
	logic rd_s1;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ucnt_q;
	logic f1z_q;
	logic [RW-1:0] f0_q;
	logic [RW-1:0] excl_q;
	logic out_vld_q;
	logic [CW-1:0] out_cnt_q;
	logic [CW-1:0] out_ucnt_q;
	logic out_pl_q;
	logic out_tpl_q;

	logic sq_mem [MAX_MODULUS];

	qcspc_pkg::cell_ctl_t ctl;
	logic [XW-1:0] f_init [5];
	logic [XW-1:0] d_init [4];
	logic [XW-1:0] s_init [3];
	logic [XW-1:0] a_init [1];
	logic [XW-1:0] fq [5];
	logic [XW-1:0] dq [4];
	logic [XW-1:0] sq [3];
	logic [XW-1:0] aq [1];

	logic cfg_ok;
	logic in_fire;
	logic out_free;
	logic [RW-1:0] a_r;
	logic [XW-1:0] a_plus_p;
	logic [RW-1:0] h;
	logic [1:0] ny;
	logic skip;
	logic [CW-1:0] cnt_inc;
	logic [CW-1:0] ucnt_inc;
	logic [CW-1:0] cnt_fin;
	logic [CW-1:0] ucnt_fin;

	assign cfg.ready = (state_q == ST_IDLE);
	assign coef.ready = (state_q == ST_IDLE) && !cfg.valid;
	assign in_fire = coef.valid && coef.ready;
	assign cfg_ok = (32'(cfg.modulus) >= 32'(qcspc_pkg::MOD_MIN))
		&& (32'(cfg.modulus) <= 32'(MAX_MODULUS));
	assign out_free = !out_vld_q || result.ready;

	assign f_init[0] = XW'(coef.coef_constant);
	assign f_init[1] = XW'(coef.coef_quadratic) + XW'(coef.coef_linear) + 8'd1;
	assign f_init[2] = {1'b0, coef.coef_quadratic, 1'b0} + 8'd14;
	assign f_init[3] = 8'd36;
	assign f_init[4] = 8'd24;
	assign d_init[0] = XW'(coef.coef_linear);
	assign d_init[1] = {1'b0, coef.coef_quadratic, 1'b0} + 8'd4;
	assign d_init[2] = 8'd24;
	assign d_init[3] = 8'd24;
	assign s_init[0] = 8'd0;
	assign s_init[1] = 8'd1;
	assign s_init[2] = 8'd2;
	assign a_init[0] = XW'(coef.coef_quadratic);

	always_comb begin
		ctl = '0;
		ctl.k = k_q;
		case (state_q)
			ST_CLR:  ctl.load = 1'b1;
			ST_IDLE: ctl.load = in_fire;
			ST_FRED: ctl.reduce = 1'b1;
			ST_RED:  ctl.reduce = 1'b1;
			ST_FILL: ctl.step = 1'b1;
			ST_RUN:  ctl.step = 1'b1;
			default: ctl = '0;
		endcase
	end

	qcspc_chain #(.N(5)) u_fchain (.clk(clk), .ctl(ctl), .p(mod_q), .init(f_init), .q(fq));
	qcspc_chain #(.N(4)) u_dchain (.clk(clk), .ctl(ctl), .p(mod_q), .init(d_init), .q(dq));
	qcspc_chain #(.N(3)) u_schain (.clk(clk), .ctl(ctl), .p(mod_q), .init(s_init), .q(sq));
	qcspc_chain #(.N(1)) u_achain (.clk(clk), .ctl(ctl), .p(mod_q), .init(a_init), .q(aq));

	// The square (f2/2)^2 is caught when the x^2 cell passes x = f2/2.
	assign a_r = aq[0][RW-1:0];
	assign a_plus_p = XW'(a_r) + XW'(mod_q);
	always_comb begin
		if (mod_q[0]) begin
			h = a_r[0] ? a_plus_p[RW:1] : (a_r >> 1);
		end else begin
			h = a_r[0] ? (mod_q >> 1) : '0;
		end
	end

	always_comb begin
		if (rd_s1) begin
			ny = 2'd2;
		end else if (vz_s1) begin
			ny = 2'd1;
		end else begin
			ny = 2'd0;
		end
	end
	assign skip = (ny == 2'd1) && dz_s1;
	assign cnt_inc = skip ? '0 : CW'(ny);
	assign ucnt_inc = skip ? '0 : CW'(2'd2 - ny);
	assign cnt_fin = cnt_q + cnt_inc;
	assign ucnt_fin = ucnt_q + ucnt_inc;

	always_ff @(posedge clk) begin
		if (state_q == ST_CLR) begin
			sq_mem[clr_q] <= 1'b0;
		end else if ((state_q == ST_FILL) && (x_q != '0)) begin
			sq_mem[AW'(sq[0])] <= 1'b1;
		end
		if (state_q == ST_RUN) begin
			rd_s1 <= sq_mem[AW'(fq[0])];
			vz_s1 <= (fq[0] == '0);
			dz_s1 <= (dq[0] == '0);
			if (x_q == '0) begin
				f1z_q <= (dq[0] == '0);
				f0_q <= fq[0][RW-1:0];
			end
			if (x_q == h) begin
				excl_q <= sq[0][RW-1:0];
			end
		end
		if (in_fire) begin
			cnt_q <= '0;
			ucnt_q <= '0;
		end else if (vld_s1 && !last_s1) begin
			cnt_q <= cnt_fin;
			ucnt_q <= ucnt_fin;
		end
		if (vld_s1 && last_s1 && out_free) begin
			out_cnt_q <= cnt_fin;
			out_ucnt_q <= ucnt_fin;
			out_pl_q <= (cnt_fin == '0);
			out_tpl_q <= (ucnt_fin == '0) && !(f1z_q && (f0_q == excl_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			mod_q <= qcspc_pkg::MOD_RESET;
			x_q <= '0;
			k_q <= qcspc_pkg::RED_FIRST;
			clr_q <= '0;
			vld_s1 <= 1'b0;
			last_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_vld_q && result.ready && (state_q != ST_WAIT)) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					k_q <= qcspc_pkg::RED_FIRST;
					if (clr_q == AW'(MAX_MODULUS - 1)) begin
						state_q <= ST_FRED;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_FRED: begin
					x_q <= '0;
					if (k_q == '0) begin
						state_q <= ST_FILL;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				ST_FILL: begin
					if (x_q == mod_q - 1'b1) begin
						state_q <= ST_IDLE;
					end else begin
						x_q <= x_q + 1'b1;
					end
				end
				ST_IDLE: begin
					k_q <= qcspc_pkg::RED_FIRST;
					x_q <= '0;
					clr_q <= '0;
					if (cfg.valid && cfg_ok) begin
						mod_q <= cfg.modulus;
						state_q <= ST_CLR;
					end else if (in_fire) begin
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					if (k_q == '0) begin
						state_q <= ST_RUN;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				ST_RUN: begin
					vld_s1 <= 1'b1;
					if (x_q == mod_q - 1'b1) begin
						last_s1 <= 1'b1;
						state_q <= ST_WAIT;
					end else begin
						x_q <= x_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						vld_s1 <= 1'b0;
						last_s1 <= 1'b0;
						out_vld_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid = out_vld_q;
	assign result.smooth_points = out_cnt_q;
	assign result.twist_points = out_ucnt_q;
	assign result.pointless = out_pl_q;
	assign result.twist_pointless = out_tpl_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(coef.ready || cfg.ready) |-> (state_q == ST_IDLE))
		else $error("handshake ready outside idle");
	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mod_q >= qcspc_pkg::MOD_MIN) && (32'(mod_q) <= MAX_MODULUS))
		else $error("modulus register out of range");
	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RUN) || (state_q == ST_FILL)) |-> (x_q < mod_q))
		else $error("sweep index beyond modulus");
	a_last_wait: assert property (@(posedge clk) disable iff (!arst_n)
		last_s1 |-> (vld_s1 && (state_q == ST_WAIT)))
		else $error("final stage outside drain");
	a_pointless: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> (out_pl_q == (out_cnt_q == '0)))
		else $error("pointless flag disagrees with count");

endmodule

// File: sv/qcspc_cell.sv
module qcspc_cell (
	input  logic                         clk,
	input  qcspc_pkg::cell_ctl_t         ctl,
	input  logic [qcspc_pkg::RES_W-1:0]  p,
	input  logic [qcspc_pkg::RAW_W-1:0]  init,
	input  logic [qcspc_pkg::RAW_W-1:0]  nb,
	output logic [qcspc_pkg::RAW_W-1:0]  q
);

	logic [qcspc_pkg::WIDE_W-1:0] pk;
	logic [qcspc_pkg::WIDE_W-1:0] qw;
	logic [qcspc_pkg::RAW_W-1:0]  sum;
	logic [qcspc_pkg::RAW_W-1:0]  pr;
	logic [qcspc_pkg::RAW_W-1:0]  q_q;

	assign pk  = qcspc_pkg::WIDE_W'(p) << ctl.k;
	assign qw  = qcspc_pkg::WIDE_W'(q_q);
	assign pr  = qcspc_pkg::RAW_W'(p);
	assign sum = q_q + nb;
	assign q   = q_q;

	// Each residue stays below p, so one subtract brings the sum back into range.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			q_q <= init;
		end else if (ctl.reduce) begin
			if (qw >= pk) begin
				q_q <= qcspc_pkg::RAW_W'(qw - pk);
			end
		end else if (ctl.step) begin
			q_q <= (sum >= pr) ? sum - pr : sum;
		end
	end

endmodule

// File: sv/qcspc_chain.sv
module qcspc_chain #(
	parameter int N = 4
) (
	input  logic                         clk,
	input  qcspc_pkg::cell_ctl_t         ctl,
	input  logic [qcspc_pkg::RES_W-1:0]  p,
	input  logic [qcspc_pkg::RAW_W-1:0]  init [N],
	output logic [qcspc_pkg::RAW_W-1:0]  q [N]
);

	// Each cell adds its right neighbor, so the head walks a polynomial by differences.
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [qcspc_pkg::RAW_W-1:0] nb;
		if (i == N - 1) begin : g_end
			assign nb = '0;
		end else begin : g_mid
			assign nb = q[i+1];
		end
		qcspc_cell u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.p    (p),
			.init (init[i]),
			.nb   (nb),
			.q    (q[i])
		);
	end

endmodule

// File: test/qcspc_tb_checker.sv
module qcspc_tb_checker (
	input  logic            clk,
	input  logic            arst_n,
	qcspc_cfg_if.sink       cfg_mon,
	qcspc_coef_if.sink      coef_mon,
	qcspc_result_if.sink    res_mon,
	output int              errors,
	output int              pending
);
	typedef struct packed {
		logic [qcspc_pkg::CNT_W-1:0] smooth;
		logic [qcspc_pkg::CNT_W-1:0] twist;
		logic pointless;
		logic twist_pointless;
	} count_t;

	count_t count_q[$];
	int prime;
	bit squares[64];

	function automatic void rebuild_squares(int p);
		for (int v = 0; v < 64; v++) squares[v] = 0;
		for (int i = 1; i < p; i++) squares[(i * i) % p] = 1;
	endfunction

	function automatic count_t count_points(int a2, int a1, int a0);
		count_t r;
		int p, f2, f1, f0, cnt, ucnt, x2, x3, x4, v, d, ny, h;
		p = prime;
		f2 = a2 % p;
		f1 = a1 % p;
		f0 = a0 % p;
		cnt = 0;
		ucnt = 0;
		for (int x = 0; x < p; x++) begin
			x2 = (x * x) % p;
			x3 = (x2 * x) % p;
			x4 = (x3 * x) % p;
			v = (x4 + f2 * x2 + f1 * x + f0) % p;
			d = (4 * x3 + ((2 * f2) % p) * x + f1) % p;
			ny = squares[v % 64] ? 2 : (v == 0 ? 1 : 0);
			if (ny == 1 && d == 0) continue;
			cnt += ny;
			ucnt += 2 - ny;
		end
		h = (((p + 1) / 2) * f2) % p;
		r.smooth = cnt[7:0];
		r.twist = ucnt[7:0];
		r.pointless = (cnt == 0);
		r.twist_pointless = (ucnt == 0) && !(f1 == 0 && f0 == (h * h) % p);
		return r;
	endfunction

	assign pending = count_q.size();

	always @(posedge clk or negedge arst_n) begin
		count_t e, a;
		if (!arst_n) begin
			prime = 3;
			rebuild_squares(3);
			count_q.delete();
			errors = 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready && cfg_mon.modulus >= 3
				&& cfg_mon.modulus <= 64) begin
				prime = cfg_mon.modulus;
				rebuild_squares(prime);
			end
			if (coef_mon.valid && coef_mon.ready)
				count_q.push_back(count_points(coef_mon.coef_quadratic,
					coef_mon.coef_linear, coef_mon.coef_constant));
			if (res_mon.valid && res_mon.ready) begin
				a = '{res_mon.smooth_points, res_mon.twist_points, res_mon.pointless,
					res_mon.twist_pointless};
				if (count_q.size() == 0) begin
					$display("%0t unexpected result beat %h", $time, a);
					errors++;
				end else begin
					e = count_q.pop_front();
					if (e.smooth !== a.smooth)
						$display("%0t smooth_points expected %0d got %0d", $time, e.smooth, a.smooth);
					if (e.twist !== a.twist)
						$display("%0t twist_points expected %0d got %0d", $time, e.twist, a.twist);
					if (e.pointless !== a.pointless)
						$display("%0t pointless expected %0b got %0b", $time, e.pointless,
							a.pointless);
					if (e.twist_pointless !== a.twist_pointless)
						$display("%0t twist_pointless expected %0b got %0b", $time,
							e.twist_pointless, a.twist_pointless);
					if (e !== a) errors++;
				end
			end
		end
	end
endmodule

// File: test/tb_quartic_curve_smooth_point_count_core.sv
module tb_quartic_curve_smooth_point_count_core;
	logic clk = 0;
	logic arst_n = 0;
	int errors, pending;
	int cycles = 0;
	bit hold_long = 0;
	bit done = 0;

	qcspc_cfg_if cfg();
	qcspc_coef_if coef();
	qcspc_result_if result();

	quartic_curve_smooth_point_count_core dut (.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.coef(coef), .result(result));
	qcspc_tb_checker chk (.clk(clk), .arst_n(arst_n), .cfg_mon(cfg), .coef_mon(coef),
		.res_mon(result), .errors(errors), .pending(pending));

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		cfg.valid = 0;
		cfg.modulus = 0;
		coef.valid = 0;
		coef.coef_quadratic = 0;
		coef.coef_linear = 0;
		coef.coef_constant = 0;
		result.ready = 0;
	end

	task automatic write_modulus(logic [6:0] m);
		cfg.valid <= 1;
		cfg.modulus <= m;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 0;
		@(negedge clk);
	endtask

	// The valid line stays high after a beat until the next gap or the drain lowers it.
	task automatic send_coefs(logic [5:0] a2, logic [5:0] a1, logic [5:0] a0, bit gaps);
		int g;
		g = gaps ? ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16)) : 0;
		if (g > 0) begin
			coef.valid <= 0;
			repeat (g) @(negedge clk);
		end
		coef.valid <= 1;
		coef.coef_quadratic <= a2;
		coef.coef_linear <= a1;
		coef.coef_constant <= a0;
		@(posedge clk);
		while (!coef.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain;
		coef.valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	always @(negedge clk) begin
		int w;
		if (!arst_n || done) result.ready <= 0;
		else if (hold_long) begin
			result.ready <= 0;
			repeat (400) @(negedge clk);
			hold_long = 0;
		end else begin
			w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
			if (w > 0) begin
				result.ready <= 0;
				repeat (w) @(negedge clk);
			end
			result.ready <= 1;
			@(posedge clk);
			while (!result.valid) @(posedge clk);
		end
	end

	initial begin
		logic [6:0] primes[6] = '{7'd3, 7'd5, 7'd7, 7'd13, 7'd31, 7'd61};
		logic [6:0] m;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_coefs(0, 0, 0, 0);
		send_coefs(63, 63, 63, 0);
		send_coefs(1, 0, 1, 0);
		drain();
		write_modulus(7'd64);
		send_coefs(0, 0, 0, 0);
		send_coefs(63, 0, 63, 0);
		drain();
		write_modulus(7'd2);
		write_modulus(7'd127);
		write_modulus(7'd0);
		write_modulus(7'd65);
		send_coefs(5, 0, 20, 0);
		send_coefs(6, 0, 9, 0);
		send_coefs(0, 63, 0, 0);
		drain();
		write_modulus(7'd5);
		send_coefs(0, 0, 0, 0);
		send_coefs(2, 0, 1, 0);
		send_coefs(4, 0, 4, 0);
		send_coefs(0, 0, 2, 0);
		send_coefs(63, 42, 21, 0);
		drain();
		write_modulus(7'd9);
		send_coefs(3, 3, 0, 0);
		send_coefs(0, 0, 0, 0);
		drain();
		for (int ph = 0; ph < 16; ph++) begin
			m = (ph % 4 == 3) ? 7'($urandom_range(0, 127)) : primes[$urandom_range(0, 5)];
			write_modulus(m);
			if (ph == 2) hold_long = 1;
			for (int n = 0; n < 100; n++) begin
				if ($urandom_range(0, 9) == 0)
					send_coefs(0, 0, 6'($urandom_range(0, 63)), 1);
				else
					send_coefs(6'($urandom), 6'($urandom), 6'($urandom), ph % 5 != 4);
			end
			drain();
		end
		done = 1;
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
